>>> sv/one_wire_temperature_read_master_core_defines.svh
// assertion macros for the one-wire temperature read master
// no dependencies; the asserting module must have clk_i and rst_ni in scope
`ifndef ONE_WIRE_TEMPERATURE_READ_MASTER_CORE_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READ_MASTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OWTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("owtr assertion failed");
`define OWTR_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("owtr assertion failed");
`else
`define OWTR_ASSERT(lbl, prop)
`define OWTR_ASSERT_NR(lbl, prop)
`endif
`endif

>>> sv/owtr_pkg.sv
// package for the one-wire temperature read master
// widths, register indexes, command bytes, result type; no dependencies
package owtr_pkg;

  localparam int unsigned TickCountBits = 12;
  localparam int unsigned CfgWidth      = 12;
  localparam int unsigned NumRegs       = 8;
  localparam int unsigned RegIdxWidth   = 3;
  localparam int unsigned WholeWidth    = 7;
  localparam int unsigned FracWidth     = 14;

  typedef logic [TickCountBits-1:0] tick_t;
  typedef logic [CfgWidth-1:0]      cfg_t;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_PRE_HIGH,
    REG_RST_LOW,
    REG_PRES_SAMPLE,
    REG_PRES_TAIL,
    REG_CMD_GAP,
    REG_WRITE_SLOT,
    REG_READ_SLOT,
    REG_SLOT_LOW
  } reg_idx_e;

  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadSpad = 8'hBE;

  localparam logic [FracWidth-1:0] FracScale = 14'd625;

  typedef struct packed {
    logic                  line_release;
    logic                  busy;
    logic                  done;
    logic                  present;
    logic [WholeWidth-1:0] whole;
    logic [FracWidth-1:0]  frac;
  } result_t;

  function automatic cfg_t reg_reset_val(reg_idx_e idx);
    cfg_t v;
    case (idx)
      REG_PRE_HIGH:    v = 12'd96;
      REG_RST_LOW:     v = 12'd960;
      REG_PRES_SAMPLE: v = 12'd96;
      REG_PRES_TAIL:   v = 12'd240;
      REG_CMD_GAP:     v = 12'd144;
      REG_WRITE_SLOT:  v = 12'd60;
      REG_READ_SLOT:   v = 12'd48;
      REG_SLOT_LOW:    v = 12'd1;
      default:         v = 12'd1;
    endcase
    return v;
  endfunction

  // zero lifts to one where asked, long counts saturate
  function automatic tick_t clamp_len(cfg_t v, logic min_one);
    cfg_t v1;
    v1 = (min_one && (v == '0)) ? cfg_t'(1) : v;
    if ((CfgWidth > TickCountBits) && ((v1 >> TickCountBits) != '0)) begin
      return '1;
    end
    return tick_t'(v1);
  endfunction

  function automatic logic [7:0] command_for(logic [2:0] step);
    logic [7:0] c;
    case (step)
      3'd2:    c = CmdConvert;
      3'd5:    c = CmdReadSpad;
      default: c = CmdSkipRom;
    endcase
    return c;
  endfunction

endpackage

>>> sv/one_wire_temperature_read_master_core.sv
// one-wire temperature read master: reset/presence, skip-rom, convert, read scratchpad
// one tick per request; results are registered in the output register or the skid
// throughput one request per cycle while the skid is empty, set by the sequencer step
// a two-entry output stage (register plus skid) absorbs one request under back-pressure
// async active-low reset: sequencer idle, results zero, timing registers to defaults
// depends on owtr_pkg and one_wire_temperature_read_master_core_defines.svh
`include "one_wire_temperature_read_master_core_defines.svh"

module one_wire_temperature_read_master_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [owtr_pkg::RegIdxWidth-1:0]        cfg_idx_i,
  input  logic [owtr_pkg::CfgWidth-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    action_i,
  input  logic                                    bus_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    line_release_o,
  output logic                                    busy_res_o,
  output logic                                    done_res_o,
  output logic                                    present_o,
  output logic [owtr_pkg::WholeWidth-1:0]         temp_whole_o,
  output logic [owtr_pkg::FracWidth-1:0]          temp_frac_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PRE_HIGH,
    PH_RST_LOW,
    PH_PRES_WAIT,
    PH_PRES_TAIL,
    PH_GAP,
    PH_W_LOW,
    PH_W_BIT,
    PH_R_LOW,
    PH_R_REC
  } phase_e;

  localparam int unsigned TB = owtr_pkg::TickCountBits;

  owtr_pkg::cfg_t cfg_q [owtr_pkg::NumRegs];

  phase_e                              phase_q, phase_d;
  owtr_pkg::tick_t                     tick_q, tick_d;
  logic [2:0]                          bit_q, bit_d;
  logic [2:0]                          byte_step_q, byte_step_d;
  logic [7:0]                          shift_q, shift_d;
  logic [7:0]                          low_q, low_d;
  logic                                pres_q, pres_d;
  logic [owtr_pkg::WholeWidth-1:0]     whole_q, whole_d;
  logic [owtr_pkg::FracWidth-1:0]      frac_q, frac_d;
  logic                                done_d;

  owtr_pkg::result_t                   res_d, out_q, skid_q;
  logic                                out_valid_q, skid_valid_q;
  logic                                step, pop;

  owtr_pkg::tick_t                     cur_len, pre_len, tail_len, gap_len;

  assign in_ready_o = !skid_valid_q;
  assign step       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  assign pre_len  = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_PRE_HIGH], 1'b0);
  assign tail_len = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_PRES_TAIL], 1'b0);
  assign gap_len  = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_CMD_GAP], 1'b0);

  always_comb begin
    case (phase_q)
      PH_PRE_HIGH:  cur_len = pre_len;
      PH_RST_LOW:   cur_len = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_RST_LOW], 1'b1);
      PH_PRES_WAIT: cur_len = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_PRES_SAMPLE], 1'b1);
      PH_PRES_TAIL: cur_len = tail_len;
      PH_GAP:       cur_len = gap_len;
      PH_W_BIT:     cur_len = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_WRITE_SLOT], 1'b1);
      PH_R_REC:     cur_len = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_READ_SLOT], 1'b1);
      PH_W_LOW,
      PH_R_LOW:     cur_len = owtr_pkg::clamp_len(cfg_q[owtr_pkg::REG_SLOT_LOW], 1'b1);
      default:      cur_len = owtr_pkg::tick_t'(1);
    endcase
  end

  always_comb begin : step_logic
    logic [TB:0] cnt;
    logic [7:0]  shift_w;
    logic [2:0]  bs_next;
    logic        gap_fin;
    logic        slot_fin;
    logic        pre_enter;
    logic        begin_byte;

    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    byte_step_d = byte_step_q;
    low_d       = low_q;
    pres_d      = pres_q;
    whole_d     = whole_q;
    frac_d      = frac_q;
    done_d      = 1'b0;
    gap_fin     = 1'b0;
    slot_fin    = 1'b0;
    pre_enter   = 1'b0;
    begin_byte  = 1'b0;
    shift_w     = shift_q;
    bs_next     = byte_step_q + 3'd1;
    cnt         = {1'b0, tick_q} + {{TB{1'b0}}, 1'b1};

    case (phase_q)
      PH_IDLE: begin
        if (action_i) begin
          pres_d      = 1'b1;
          byte_step_d = '0;
          bit_d       = '0;
          pre_enter   = 1'b1;
        end
      end
      default: begin
        // read slot samples the line on its first recovery tick
        if ((phase_q == PH_R_REC) && (tick_q == '0)) begin
          shift_w = {bus_in_i, shift_q[7:1]};
        end
        if (cnt >= {1'b0, cur_len}) begin
          tick_d = '0;
          case (phase_q)
            PH_PRE_HIGH: phase_d = PH_RST_LOW;
            PH_RST_LOW:  phase_d = PH_PRES_WAIT;
            PH_PRES_WAIT: begin
              if (bus_in_i) begin
                pres_d = 1'b0;
              end
              if (tail_len != '0) begin
                phase_d = PH_PRES_TAIL;
              end else if (gap_len != '0) begin
                phase_d = PH_GAP;
              end else begin
                gap_fin = 1'b1;
              end
            end
            PH_PRES_TAIL: begin
              if (gap_len != '0) begin
                phase_d = PH_GAP;
              end else begin
                gap_fin = 1'b1;
              end
            end
            PH_GAP:   gap_fin = 1'b1;
            PH_W_LOW: phase_d = PH_W_BIT;
            PH_W_BIT: begin
              shift_w  = {1'b0, shift_q[7:1]};
              slot_fin = 1'b1;
            end
            PH_R_LOW: phase_d = PH_R_REC;
            PH_R_REC: slot_fin = 1'b1;
            default:  phase_d = PH_IDLE;
          endcase
        end else begin
          tick_d = cnt[TB-1:0];
        end
      end
    endcase

    shift_d = shift_w;

    if (gap_fin) begin
      byte_step_d = bs_next;
      begin_byte  = 1'b1;
    end

    if (slot_fin) begin
      if (bit_q != 3'd7) begin
        bit_d   = bit_q + 3'd1;
        phase_d = (byte_step_q[2:1] == 2'b11) ? PH_R_LOW : PH_W_LOW;
      end else begin
        bit_d = '0;
        if (byte_step_q == 3'd7) begin
          whole_d     = {shift_w[2:0], low_q[7:4]};
          frac_d      = {10'd0, low_q[3:0]} * owtr_pkg::FracScale;
          done_d      = 1'b1;
          byte_step_d = '0;
          phase_d     = PH_IDLE;
        end else begin
          if (byte_step_q == 3'd6) begin
            low_d = shift_w;
          end
          if (byte_step_q == 3'd2) begin
            byte_step_d = 3'd3;
            pre_enter   = 1'b1;
          end else begin
            byte_step_d = bs_next;
            begin_byte  = 1'b1;
          end
        end
      end
    end

    if (begin_byte) begin
      bit_d = '0;
      if (byte_step_d[2:1] == 2'b11) begin
        shift_d = '0;
        phase_d = PH_R_LOW;
      end else begin
        shift_d = owtr_pkg::command_for(byte_step_d);
        phase_d = PH_W_LOW;
      end
    end

    if (pre_enter) begin
      tick_d  = '0;
      phase_d = (pre_len != '0) ? PH_PRE_HIGH : PH_RST_LOW;
    end

    case (phase_q)
      PH_RST_LOW,
      PH_W_LOW,
      PH_R_LOW: res_d.line_release = 1'b0;
      PH_W_BIT: res_d.line_release = shift_q[0];
      default:  res_d.line_release = 1'b1;
    endcase
    res_d.busy    = (phase_q != PH_IDLE);
    res_d.done    = done_d;
    res_d.present = pres_d;
    res_d.whole   = whole_d;
    res_d.frac    = frac_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < owtr_pkg::NumRegs; i++) begin
        cfg_q[i] <= owtr_pkg::reg_reset_val(owtr_pkg::reg_idx_e'(i));
      end
      phase_q      <= PH_IDLE;
      tick_q       <= '0;
      bit_q        <= '0;
      byte_step_q  <= '0;
      shift_q      <= '0;
      low_q        <= '0;
      pres_q       <= 1'b0;
      whole_q      <= '0;
      frac_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
      if (step) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        bit_q       <= bit_d;
        byte_step_q <= byte_step_d;
        shift_q     <= shift_d;
        low_q       <= low_d;
        pres_q      <= pres_d;
        whole_q     <= whole_d;
        frac_q      <= frac_d;
      end
      if (skid_valid_q) begin
        if (pop) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (step) begin
        if (!out_valid_q || pop) begin
          out_q       <= res_d;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res_d;
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_release_o = out_q.line_release;
  assign busy_res_o     = out_q.busy;
  assign done_res_o     = out_q.done;
  assign present_o      = out_q.present;
  assign temp_whole_o   = out_q.whole;
  assign temp_frac_o    = out_q.frac;

  `OWTR_ASSERT_NR(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `OWTR_ASSERT(a_done_while_busy, (out_valid_q && out_q.done) |-> out_q.busy)
  `OWTR_ASSERT(a_idle_counters_clear, (phase_q == PH_IDLE) |-> (bit_q == '0 && byte_step_q == '0))
  `OWTR_ASSERT(a_read_slot_step, (phase_q == PH_R_LOW || phase_q == PH_R_REC) |-> (byte_step_q[2:1] == 2'b11))

endmodule
